/* src/cpg_pkg.sv */
// ----------------------------------------------------------------------------
// cpg_pkg
// Shared types, constants and helper functions of the circle pixel generator.
// ----------------------------------------------------------------------------
`default_nettype none

package cpg_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_PIXEL_IS_WIDE = 2'd2;

  // Configuration reset values.
  localparam logic [12:0] SCREEN_WIDTH_RESET  = 13'd800;
  localparam logic [12:0] SCREEN_HEIGHT_RESET = 13'd480;
  localparam logic        PIXEL_IS_WIDE_RESET = 1'b1;

  // Decision variable constants of the midpoint recurrence.
  localparam logic [11:0] DEC_INIT      = 12'd3;
  localparam logic [11:0] DEC_ADD_INNER = 12'd6;
  localparam logic [11:0] DEC_ADD_OUTER = 12'd10;

  // Index of the eighth point of a step.
  localparam logic [2:0] LAST_POINT = 3'd7;

  // RGB565 field masks.
  localparam logic [31:0] MASK_BLUE  = 32'h0000_00F8;
  localparam logic [31:0] MASK_GREEN = 32'h0000_FC00;
  localparam logic [31:0] MASK_RED   = 32'h00F8_0000;

  typedef struct packed {
    logic        action;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [7:0]  radius;
    logic [31:0] draw_color;
  } in_item_t;

  typedef struct packed {
    logic        write_enable;
    logic [23:0] pixel_index;
    logic [31:0] pixel_data;
    logic        last;
    logic        done_res;
  } out_item_t;

  // One step's worth of work handed from the stepper to the emitter.
  typedef struct packed {
    logic        done;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [31:0] color;
  } job_t;

  // Screen settings as the emitter sees them, dimensions already saturated.
  typedef struct packed {
    logic [12:0] width;
    logic [12:0] height;
    logic        wide;
  } screen_cfg_t;

  // How one mirrored point is formed from the offsets a and b.
  typedef struct packed {
    logic x_from_b;
    logic x_neg;
    logic y_from_b;
    logic y_neg;
  } octant_t;

  // Point order of a step: (+a,-b) (+b,-a) (+b,+a) (+a,+b)
  // (-a,+b) (-b,+a) (-a,-b) (-b,-a).
  function automatic octant_t octant_map(input logic [2:0] k);
    octant_t o;
    case (k)
      3'd0:    o = '{x_from_b: 1'b0, x_neg: 1'b0, y_from_b: 1'b1, y_neg: 1'b1};
      3'd1:    o = '{x_from_b: 1'b1, x_neg: 1'b0, y_from_b: 1'b0, y_neg: 1'b1};
      3'd2:    o = '{x_from_b: 1'b1, x_neg: 1'b0, y_from_b: 1'b0, y_neg: 1'b0};
      3'd3:    o = '{x_from_b: 1'b0, x_neg: 1'b0, y_from_b: 1'b1, y_neg: 1'b0};
      3'd4:    o = '{x_from_b: 1'b0, x_neg: 1'b1, y_from_b: 1'b1, y_neg: 1'b0};
      3'd5:    o = '{x_from_b: 1'b1, x_neg: 1'b1, y_from_b: 1'b0, y_neg: 1'b0};
      3'd6:    o = '{x_from_b: 1'b0, x_neg: 1'b1, y_from_b: 1'b1, y_neg: 1'b1};
      default: o = '{x_from_b: 1'b1, x_neg: 1'b1, y_from_b: 1'b0, y_neg: 1'b1};
    endcase
    return o;
  endfunction

  // Pack 0xAARRGGBB into RGB565 in the low 16 bits.
  function automatic logic [31:0] rgb565(input logic [31:0] c);
    return ((c & MASK_BLUE) >> 3) | ((c & MASK_GREEN) >> 5) | ((c & MASK_RED) >> 8);
  endfunction

endpackage

`default_nettype wire

/* src/cpg_stepper.sv */
// ----------------------------------------------------------------------------
// cpg_stepper
// Circle state and the midpoint decision recurrence, one update per item.
// ----------------------------------------------------------------------------
`default_nettype none

module cpg_stepper (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  cpg_pkg::in_item_t    item,
  output logic                 job_load,
  output cpg_pkg::job_t        job
);
  import cpg_pkg::*;

  logic        running;
  logic [15:0] origin_x;
  logic [15:0] origin_y;
  logic [7:0]  offset_a;
  logic [7:0]  offset_b;
  logic [11:0] decision;
  logic [31:0] held_color;

  logic        dec_neg;
  logic [8:0]  a_inc;
  logic        done;
  logic [11:0] four_a;
  logic [11:0] four_b;
  logic [11:0] decision_next;
  logic [7:0]  offset_b_next;
  logic        is_step;

  // Next offsets and decision value, judged on the incremented a.
  always_comb begin
    dec_neg = decision[11];
    a_inc   = {1'b0, offset_a} + 9'd1;
    four_a  = {1'b0, a_inc, 2'b00};
    four_b  = {2'b00, offset_b, 2'b00};
    if (dec_neg) begin
      decision_next = decision + four_a + DEC_ADD_INNER;
      offset_b_next = offset_b;
      done          = a_inc > {1'b0, offset_b};
    end else begin
      decision_next = decision + DEC_ADD_OUTER + four_a - four_b;
      offset_b_next = offset_b - 8'd1;
      done          = a_inc >= {1'b0, offset_b};
    end
  end

  // A step item only produces points while a circle is running.
  assign is_step  = item.action && running;
  assign job_load = accept && is_step;

  assign job.done  = done;
  assign job.cx    = origin_x;
  assign job.cy    = origin_y;
  assign job.a     = offset_a;
  assign job.b     = offset_b;
  assign job.color = held_color;

  // Start items load the circle; step items advance it.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
    end else if (accept && !item.action) begin
      running <= 1'b1;
    end else if (job_load && done) begin
      running <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !item.action) begin
      origin_x   <= item.center_x;
      origin_y   <= item.center_y;
      held_color <= item.draw_color;
      offset_a   <= 8'd0;
      offset_b   <= item.radius;
      decision   <= DEC_INIT - {3'b000, item.radius, 1'b0};
    end else if (job_load) begin
      offset_a   <= a_inc[7:0];
      offset_b   <= offset_b_next;
      decision   <= decision_next;
    end
  end

endmodule

`default_nettype wire

/* src/cpg_emitter.sv */
// ----------------------------------------------------------------------------
// cpg_emitter
// Walks the eight mirrored points of a step, clips each one and registers
// the pixel write.
// ----------------------------------------------------------------------------
`default_nettype none

module cpg_emitter (
  input  wire logic             clk,
  input  wire logic             rst,
  input  cpg_pkg::screen_cfg_t  cfg,
  input  wire logic             job_load,
  input  cpg_pkg::job_t         job,
  output logic                  job_free,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output cpg_pkg::out_item_t    out_data
);
  import cpg_pkg::*;

  logic          busy;
  logic [2:0]    k;
  job_t          job_r;

  logic          adv;
  logic          finishing;
  octant_t       oct;
  logic [7:0]    dx;
  logic [7:0]    dy;
  logic [17:0]   px;
  logic [17:0]   py;
  logic          vis;
  logic [25:0]   row_base;
  logic [25:0]   lin;
  out_item_t     point;

  // A point moves into the output register whenever that register is free.
  assign adv       = busy && (!out_valid || out_ready);
  assign finishing = adv && (k == LAST_POINT);
  assign job_free  = !busy || finishing;

  // Mirror, clip and linearize the current point.
  always_comb begin
    oct = octant_map(k);
    dx  = oct.x_from_b ? job_r.b : job_r.a;
    dy  = oct.y_from_b ? job_r.b : job_r.a;
    px  = oct.x_neg ? ({2'b00, job_r.cx} - {10'd0, dx}) : ({2'b00, job_r.cx} + {10'd0, dx});
    py  = oct.y_neg ? ({2'b00, job_r.cy} - {10'd0, dy}) : ({2'b00, job_r.cy} + {10'd0, dy});
    vis = !px[17] && !py[17] &&
          (px[16:0] < {4'b0000, cfg.width}) && (py[16:0] < {4'b0000, cfg.height});
    row_base = py[12:0] * cfg.width;
    lin      = row_base + {13'd0, px[12:0]};

    point.write_enable = vis;
    point.pixel_index  = vis ? lin[23:0] : 24'd0;
    point.pixel_data   = vis ? (cfg.wide ? job_r.color : rgb565(job_r.color)) : 32'd0;
    point.last         = (k == LAST_POINT);
    point.done_res     = job_r.done;
  end

  // Job and point counter control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      k    <= 3'd0;
    end else begin
      if (adv) begin
        k <= k + 3'd1;
      end
      if (job_load) begin
        busy <= 1'b1;
        k    <= 3'd0;
      end else if (finishing) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job_r <= job;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= point;
    end
  end

  // A job never ends before its eighth point has left.
  a_no_early_end: assert property (@(posedge clk) disable iff (rst)
    (busy && adv && (k != LAST_POINT)) |=> busy)
    else $error("job ended before its last point");

  // A new job is taken over a busy one only as the last point leaves.
  a_handover: assert property (@(posedge clk) disable iff (rst)
    (busy && job_free) |-> (k == LAST_POINT && adv))
    else $error("job handover before the last point");

  // A stalled output freezes the point counter.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (busy && out_valid && !out_ready) |=> $stable(k))
    else $error("point counter moved during a stall");

endmodule

`default_nettype wire

/* src/circle_pixel_generator.sv */
// ----------------------------------------------------------------------------
// circle_pixel_generator
// Midpoint circle rasterizer that turns circle steps into framebuffer writes.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Handshake              Payload
//   in       in   in_valid / in_ready    in_data   (cpg_pkg::in_item_t)
//   out      out  out_valid / out_ready  out_data  (cpg_pkg::out_item_t)
//   cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A start item produces no writes. A step item produces eight writes, one per
// cycle while out_ready does not stall. The step is held in the job register
// and each point then passes through the single output register, which
// carries one point a cycle. The next item is taken in the cycle its
// predecessor's eighth point moves into the output register. Reset is
// synchronous; no clearing pass follows. in_ready is low while a step's
// points are emitted, and a stall on out_ready holds the point counter and
// so keeps in_ready low.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_pixel_generator #(
  parameter int MAX_SCREEN_WIDTH  = 4096,
  parameter int MAX_SCREEN_HEIGHT = 4096
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  cpg_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output cpg_pkg::out_item_t  out_data,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [12:0]    cfg_data
);
  import cpg_pkg::*;

  logic [12:0]  screen_width;
  logic [12:0]  screen_height;
  logic         pixel_is_wide;
  screen_cfg_t  cfg;
  logic         in_accept;
  logic         job_load;
  job_t         job;
  logic         job_free;

  // Configuration registers, always writable.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RESET;
      screen_height <= SCREEN_HEIGHT_RESET;
      pixel_is_wide <= PIXEL_IS_WIDE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
        CFG_PIXEL_IS_WIDE: pixel_is_wide <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Screen dimensions saturate at the supported maxima.
  always_comb begin
    cfg.width  = ({4'b0000, screen_width} > 17'(MAX_SCREEN_WIDTH)) ?
                 13'(MAX_SCREEN_WIDTH) : screen_width;
    cfg.height = ({4'b0000, screen_height} > 17'(MAX_SCREEN_HEIGHT)) ?
                 13'(MAX_SCREEN_HEIGHT) : screen_height;
    cfg.wide   = pixel_is_wide;
  end

  assign in_ready  = job_free;
  assign in_accept = in_valid && in_ready;

  cpg_stepper u_stepper (
    .clk      (clk),
    .rst      (rst),
    .accept   (in_accept),
    .item     (in_data),
    .job_load (job_load),
    .job      (job)
  );

  cpg_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_load  (job_load),
    .job       (job),
    .job_free  (job_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
